### rtl/core/ldbr_pkg.sv
`default_nettype none

package ldbr_pkg;

  // Button and event codes
  typedef enum logic [2:0] {
    BTN_NONE      = 3'd0,
    BTN_MODE      = 3'd1,
    BTN_PLUS      = 3'd2,
    BTN_MINUS     = 3'd3,
    BTN_RESTART   = 3'd4,
    BTN_MODE_HELD = 3'd5
  } btn_e;

  // Item actions
  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_IGNORE = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PLUS_LOW     = 3'd0,
    REG_PLUS_HIGH    = 3'd1,
    REG_MINUS_LOW    = 3'd2,
    REG_MINUS_HIGH   = 3'd3,
    REG_RESTART_LOW  = 3'd4,
    REG_RESTART_HIGH = 3'd5,
    REG_REPEAT_DELAY = 3'd6,
    REG_HOLD_DELAY   = 3'd7
  } reg_idx_e;

  localparam logic [15:0] RepeatDelayReset = 16'd250;
  localparam logic [15:0] HoldDelayReset   = 16'd1000;

  typedef struct packed {
    logic [9:0]  plus_low;
    logic [9:0]  plus_high;
    logic [9:0]  minus_low;
    logic [9:0]  minus_high;
    logic [9:0]  restart_low;
    logic [9:0]  restart_high;
    logic [15:0] repeat_delay_ms;
    logic [15:0] hold_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [9:0]  ladder_value;
    logic        mode_pin_low;
    logic [15:0] ignore_ms;
  } item_t;

endpackage

`default_nettype wire

### rtl/core/ldbr_cfg_regs.sv
`default_nettype none

module ldbr_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i,
  output ldbr_pkg::cfg_t    cfg_o
);
  import ldbr_pkg::*;

  cfg_t cfg_q;

  // Write one register per enabled cycle, truncated to its width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{plus_low: 10'd0, plus_high: 10'd0, minus_low: 10'd0, minus_high: 10'd0,
                 restart_low: 10'd0, restart_high: 10'd0,
                 repeat_delay_ms: RepeatDelayReset, hold_delay_ms: HoldDelayReset};
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PLUS_LOW:     cfg_q.plus_low        <= cfg_data_i[9:0];
        REG_PLUS_HIGH:    cfg_q.plus_high       <= cfg_data_i[9:0];
        REG_MINUS_LOW:    cfg_q.minus_low       <= cfg_data_i[9:0];
        REG_MINUS_HIGH:   cfg_q.minus_high      <= cfg_data_i[9:0];
        REG_RESTART_LOW:  cfg_q.restart_low     <= cfg_data_i[9:0];
        REG_RESTART_HIGH: cfg_q.restart_high    <= cfg_data_i[9:0];
        REG_REPEAT_DELAY: cfg_q.repeat_delay_ms <= cfg_data_i;
        REG_HOLD_DELAY:   cfg_q.hold_delay_ms   <= cfg_data_i;
        default:          cfg_q                 <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/ldbr_classify.sv
`default_nettype none

module ldbr_classify (
  input  wire logic         mode_pin_low_i,
  input  wire logic [9:0]   ladder_value_i,
  input  ldbr_pkg::cfg_t    cfg_i,
  output ldbr_pkg::btn_e    btn_o
);
  import ldbr_pkg::*;

  logic hit_plus, hit_minus, hit_restart;

  // Match the reading against each window; an inverted window never hits
  assign hit_plus    = (ladder_value_i >= cfg_i.plus_low) &&
                       (ladder_value_i <= cfg_i.plus_high);
  assign hit_minus   = (ladder_value_i >= cfg_i.minus_low) &&
                       (ladder_value_i <= cfg_i.minus_high);
  assign hit_restart = (ladder_value_i >= cfg_i.restart_low) &&
                       (ladder_value_i <= cfg_i.restart_high);

  // Mode pin first, then plus, minus, restart
  always_comb begin
    priority if (mode_pin_low_i) begin
      btn_o = BTN_MODE;
    end else if (hit_plus) begin
      btn_o = BTN_PLUS;
    end else if (hit_minus) begin
      btn_o = BTN_MINUS;
    end else if (hit_restart) begin
      btn_o = BTN_RESTART;
    end else begin
      btn_o = BTN_NONE;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ldbr_step.sv
`default_nettype none

module ldbr_step #(
  parameter int unsigned DEBOUNCE_MS = 50
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  ldbr_pkg::item_t   item_i,
  input  ldbr_pkg::btn_e    btn_i,
  input  ldbr_pkg::cfg_t    cfg_i,
  output ldbr_pkg::btn_e    event_o,
  output logic [31:0]       last_press_o
);
  import ldbr_pkg::*;

  localparam logic [31:0] DebounceMs = 32'(DEBOUNCE_MS);

  btn_e        cand_q, cand_d;
  btn_e        rec_q, rec_d;
  logic [31:0] db_start_q, db_start_d;
  logic [31:0] press_q, press_d;
  logic [31:0] ign_until_q, ign_until_d;

  logic [31:0] remaining, db_elapsed, held;
  logic        in_ignore, is_plus_minus;

  // Wrap-safe time differences
  assign remaining  = ign_until_q - item_i.now_ms;
  assign db_elapsed = item_i.now_ms - db_start_q;
  assign held       = item_i.now_ms - press_q;
  assign in_ignore  = (remaining != '0) && (remaining[31:16] == '0);
  assign is_plus_minus = (btn_i == BTN_PLUS) || (btn_i == BTN_MINUS);

  // Next state and event for the item in the input register
  always_comb begin
    cand_d      = cand_q;
    rec_d       = rec_q;
    db_start_d  = db_start_q;
    press_d     = press_q;
    ign_until_d = ign_until_q;
    event_o     = BTN_NONE;
    unique case (action_e'(item_i.action))
      ACT_SAMPLE: begin
        priority if (in_ignore) begin
          event_o = BTN_NONE;
        end else if (btn_i != cand_q) begin
          cand_d     = btn_i;
          db_start_d = item_i.now_ms;
        end else if (db_elapsed < DebounceMs) begin
          event_o = BTN_NONE;
        end else if (btn_i != rec_q) begin
          rec_d   = btn_i;
          press_d = item_i.now_ms;
          event_o = btn_i;
        end else if (is_plus_minus && (held > {16'd0, cfg_i.repeat_delay_ms})) begin
          press_d = item_i.now_ms;
          event_o = btn_i;
        end else if ((btn_i == BTN_MODE) && (held > {16'd0, cfg_i.hold_delay_ms})) begin
          event_o = BTN_MODE_HELD;
        end else begin
          event_o = BTN_NONE;
        end
      end
      ACT_IGNORE: begin
        ign_until_d = item_i.now_ms + {16'd0, item_i.ignore_ms};
      end
      ACT_CLEAR: begin
        rec_d       = BTN_NONE;
        press_d     = item_i.now_ms;
        ign_until_d = item_i.now_ms;
      end
      default: begin
        event_o = BTN_NONE;
      end
    endcase
  end

  assign last_press_o = press_d;

  // Commit state when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q      <= BTN_NONE;
      rec_q       <= BTN_NONE;
      db_start_q  <= '0;
      press_q     <= '0;
      ign_until_q <= '0;
    end else if (step_i) begin
      cand_q      <= cand_d;
      rec_q       <= rec_d;
      db_start_q  <= db_start_d;
      press_q     <= press_d;
      ign_until_q <= ign_until_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ladder_button_debounce_repeat.sv
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while the output is not stalled; input and result registers each hold one item.
// Each item's state update is a single pass of compares and 32-bit subtracts.
// Reset (rst_ni low, asynchronous): pipeline empty, button state and times
// cleared, windows 0, repeat delay 250 ms, hold delay 1000 ms.
`default_nettype none

module ladder_button_debounce_repeat #(
  parameter int unsigned DEBOUNCE_MS = 50
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [9:0]  ladder_value_i,
  input  wire logic        mode_pin_low_i,
  input  wire logic [15:0] ignore_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_res_o,
  output logic [31:0]      last_press_ms_o
);
  import ldbr_pkg::*;

  cfg_t        cfg;
  item_t       item_q;
  logic        item_vld_q;
  btn_e        btn, step_event;
  logic [31:0] step_press;
  logic        res_vld_q;
  logic [2:0]  res_event_q;
  logic [31:0] res_press_q;
  logic        res_free, item_free, step;

  // Handshake: result slot frees on output transfer, input slot on advance
  assign res_free   = !res_vld_q || !out_stall_i;
  assign step       = item_vld_q && res_free;
  assign item_free  = !item_vld_q || res_free;
  assign in_stall_o = !item_free;

  ldbr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Hold the input item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (item_free) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_free && in_valid_i) begin
      item_q.action       <= action_i;
      item_q.now_ms       <= now_ms_i;
      item_q.ladder_value <= ladder_value_i;
      item_q.mode_pin_low <= mode_pin_low_i;
      item_q.ignore_ms    <= ignore_ms_i;
    end
  end

  ldbr_classify u_classify (
    .mode_pin_low_i (item_q.mode_pin_low),
    .ladder_value_i (item_q.ladder_value),
    .cfg_i          (cfg),
    .btn_o          (btn)
  );

  ldbr_step #(
    .DEBOUNCE_MS (DEBOUNCE_MS)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (item_q),
    .btn_i        (btn),
    .cfg_i        (cfg),
    .event_o      (step_event),
    .last_press_o (step_press)
  );

  // Hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_event_q <= step_event;
      res_press_q <= step_press;
    end
  end

  assign out_valid_o     = res_vld_q;
  assign event_res_o     = res_event_q;
  assign last_press_ms_o = res_press_q;

endmodule

`default_nettype wire

### rtl/core/ldbr_checker.sv
`default_nettype none

module ldbr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  event_res_o,
  input wire logic [31:0] last_press_ms_o
);

  // Stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Stalled result payload holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(event_res_o) && $stable(last_press_ms_o))
    else $error("result payload changed while stalled");

  // Empty result slot never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result slot");

  // Accepted item passes from the input register to the result register and is offered when the output is not stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted item did not produce a result");

endmodule

bind ladder_button_debounce_repeat ldbr_checker u_ldbr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .event_res_o     (event_res_o),
  .last_press_ms_o (last_press_ms_o)
);

`default_nettype wire
